// File: sv/wrr_pkg.sv
// wrr_pkg: widths, register indexes and pipeline word types for window_rect_remap.
// No dependencies; imported by window_rect_remap, wrr_checker and the testbench.
package wrr_pkg;

  localparam int COORD_BITS   = 16;
  localparam int PROD_BITS    = 2 * COORD_BITS;
  localparam int DIV_STEPS    = PROD_BITS;
  localparam int EXT_BITS     = COORD_BITS + 3;
  localparam int NUM_REGS     = 8;
  localparam int REG_IDX_BITS = $clog2(NUM_REGS);

  typedef logic [COORD_BITS-1:0]      coord_t;
  typedef logic signed [EXT_BITS-1:0] ext_t;
  typedef logic [REG_IDX_BITS-1:0]    reg_idx_t;

  localparam reg_idx_t REG_SRC_X = REG_IDX_BITS'(0);
  localparam reg_idx_t REG_SRC_Y = REG_IDX_BITS'(1);
  localparam reg_idx_t REG_SRC_W = REG_IDX_BITS'(2);
  localparam reg_idx_t REG_SRC_H = REG_IDX_BITS'(3);
  localparam reg_idx_t REG_DST_X = REG_IDX_BITS'(4);
  localparam reg_idx_t REG_DST_Y = REG_IDX_BITS'(5);
  localparam reg_idx_t REG_DST_W = REG_IDX_BITS'(6);
  localparam reg_idx_t REG_DST_H = REG_IDX_BITS'(7);

  // overhangs measured against the source rectangle
  typedef struct packed {
    coord_t                low;
    logic [COORD_BITS:0]   high;
    coord_t                offset;
    coord_t                size;
  } clip_t;

  // clipped size resolved, free spans known
  typedef struct packed {
    coord_t low;
    coord_t offset;
    coord_t fsrc;
    coord_t fdst;
    logic   do_div;
    coord_t size_new;
  } span_t;

  // one restoring-division step
  typedef struct packed {
    coord_t                rem;
    logic [PROD_BITS-1:0]  num;
    coord_t                quo;
    coord_t                dvs;
    coord_t                low;
    coord_t                size_new;
  } div_t;

endpackage

// File: sv/window_rect_remap.sv
// window_rect_remap: remaps one window rectangle from the source to the destination
// screen rectangle held in the config registers. Depends on wrr_pkg.
//
// Usage:
//   cfg port: write cfg_wdata into register cfg_index while cfg_wr_en is high
//     (0 src x, 1 src y, 2 src width, 3 src height, 4..7 same for destination).
//     Write only while the pipeline is empty.
//   in channel: one window word (x, y, width, height) taken when in_valid is high
//     and in_stall is low.
//   out channel: one remapped word per input word, in order.
// Pipeline depth: 36 register stages.
// Throughput: one word per cycle while out_stall does not hold the pipeline.
// Stages: overhang measure, clip and free spans, 16x16 multiply, 32 one-bit
// restoring divide steps (the 32-bit product over the free source span), final sum.
// All stages move together; when out_valid is high and out_stall is high the whole
// pipeline holds and in_stall is raised in the same cycle.
// Reset: config registers clear to 0 and all stage valid bits drop; words in flight are lost.
module window_rect_remap
  import wrr_pkg::*;
(
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_wr_en,
  input  logic [REG_IDX_BITS-1:0]       cfg_index,
  input  logic [COORD_BITS-1:0]         cfg_wdata,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [COORD_BITS-1:0]  in_win_x,
  input  logic signed [COORD_BITS-1:0]  in_win_y,
  input  logic [COORD_BITS-1:0]         in_win_width,
  input  logic [COORD_BITS-1:0]         in_win_height,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COORD_BITS-1:0]  out_new_x,
  output logic signed [COORD_BITS-1:0]  out_new_y,
  output logic [COORD_BITS-1:0]         out_new_width,
  output logic [COORD_BITS-1:0]         out_new_height
);

  coord_t src_x_r, src_y_r, src_w_r, src_h_r;
  coord_t dst_x_r, dst_y_r, dst_w_r, dst_h_r;

  logic                 adv;
  logic                 v1_r, v2_r;
  logic [DIV_STEPS:0]   dv_r;
  logic                 out_valid_r;
  clip_t                cx_r, cy_r;
  span_t                sx_r, sy_r;
  div_t                 dx_r [DIV_STEPS+1];
  div_t                 dy_r [DIV_STEPS+1];
  coord_t               out_x_r, out_y_r, out_w_r, out_h_r;

  function automatic clip_t clip_axis(coord_t pos, coord_t size, coord_t spos,
                                      coord_t ssize);
    ext_t  p, s, sp, ss, low_raw, high_raw, off_raw;
    clip_t r;
    p        = ext_t'(signed'(pos));
    sp       = ext_t'(signed'(spos));
    s        = ext_t'(size);
    ss       = ext_t'(ssize);
    low_raw  = sp - p;
    high_raw = p + s - sp - ss;
    off_raw  = p - sp;
    r.low    = low_raw[EXT_BITS-1]  ? '0 : low_raw[COORD_BITS-1:0];
    r.high   = high_raw[EXT_BITS-1] ? '0 : high_raw[COORD_BITS:0];
    r.offset = off_raw[EXT_BITS-1]  ? '0 : off_raw[COORD_BITS-1:0];
    r.size   = size;
    return r;
  endfunction

  function automatic span_t span_axis(clip_t c, coord_t ssize, coord_t dsize);
    ext_t   clip_raw, fs, fd;
    coord_t clipped;
    span_t  r;
    clip_raw   = ext_t'(c.size) - ext_t'(c.low) - ext_t'(c.high);
    clipped    = (clip_raw[EXT_BITS-1] || clip_raw == '0) ? COORD_BITS'(1)
                                                          : clip_raw[COORD_BITS-1:0];
    r.size_new = COORD_BITS'(ext_t'(clipped) + ext_t'(c.low) + ext_t'(c.high));
    fs         = ext_t'(ssize) - ext_t'(clipped);
    fd         = ext_t'(dsize) - ext_t'(clipped);
    r.do_div   = !fs[EXT_BITS-1] && (fs != '0) && !fd[EXT_BITS-1] && (fd != '0) &&
                 (c.offset != '0);
    r.fsrc     = fs[COORD_BITS-1:0];
    r.fdst     = fd[COORD_BITS-1:0];
    r.low      = c.low;
    r.offset   = c.offset;
    return r;
  endfunction

  function automatic div_t mult_axis(span_t s);
    div_t r;
    r.num      = s.do_div ? PROD_BITS'(s.offset) * PROD_BITS'(s.fdst) : '0;
    r.dvs      = s.do_div ? s.fsrc : COORD_BITS'(1);
    r.rem      = '0;
    r.quo      = '0;
    r.low      = s.low;
    r.size_new = s.size_new;
    return r;
  endfunction

  // only the low quotient bits are kept; the remainder is carried to the next step
  function automatic div_t div_step(div_t d);
    logic [COORD_BITS:0] trial, diff;
    logic                ge;
    div_t                r;
    trial = {d.rem, d.num[PROD_BITS-1]};
    diff  = trial - {1'b0, d.dvs};
    ge    = !diff[COORD_BITS];
    r     = d;
    r.rem = ge ? diff[COORD_BITS-1:0] : trial[COORD_BITS-1:0];
    r.num = d.num << 1;
    r.quo = {d.quo[COORD_BITS-2:0], ge};
    return r;
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      src_x_r <= '0; src_y_r <= '0; src_w_r <= '0; src_h_r <= '0;
      dst_x_r <= '0; dst_y_r <= '0; dst_w_r <= '0; dst_h_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_SRC_X: src_x_r <= cfg_wdata;
        REG_SRC_Y: src_y_r <= cfg_wdata;
        REG_SRC_W: src_w_r <= cfg_wdata;
        REG_SRC_H: src_h_r <= cfg_wdata;
        REG_DST_X: dst_x_r <= cfg_wdata;
        REG_DST_Y: dst_y_r <= cfg_wdata;
        REG_DST_W: dst_w_r <= cfg_wdata;
        REG_DST_H: dst_h_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      dv_r        <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      dv_r        <= {dv_r[DIV_STEPS-1:0], v2_r};
      out_valid_r <= dv_r[DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      cx_r     <= clip_axis(in_win_x, in_win_width, src_x_r, src_w_r);
      cy_r     <= clip_axis(in_win_y, in_win_height, src_y_r, src_h_r);
      sx_r     <= span_axis(cx_r, src_w_r, dst_w_r);
      sy_r     <= span_axis(cy_r, src_h_r, dst_h_r);
      dx_r[0]  <= mult_axis(sx_r);
      dy_r[0]  <= mult_axis(sy_r);
      for (int k = 1; k <= DIV_STEPS; k++) begin
        dx_r[k] <= div_step(dx_r[k-1]);
        dy_r[k] <= div_step(dy_r[k-1]);
      end
      out_x_r  <= dst_x_r + dx_r[DIV_STEPS].quo - dx_r[DIV_STEPS].low;
      out_y_r  <= dst_y_r + dy_r[DIV_STEPS].quo - dy_r[DIV_STEPS].low;
      out_w_r  <= dx_r[DIV_STEPS].size_new;
      out_h_r  <= dy_r[DIV_STEPS].size_new;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_new_x      = signed'(out_x_r);
  assign out_new_y      = signed'(out_y_r);
  assign out_new_width  = out_w_r;
  assign out_new_height = out_h_r;

endmodule

// File: sv/wrr_checker.sv
// wrr_checker: port-level assertions for window_rect_remap, bound into window_rect_remap.
// Depends on wrr_pkg and window_rect_remap.
module wrr_checker
  import wrr_pkg::*;
(
  input logic                          clk,
  input logic                          rst_n,
  input logic                          in_stall,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic signed [COORD_BITS-1:0]  out_new_x,
  input logic signed [COORD_BITS-1:0]  out_new_y,
  input logic [COORD_BITS-1:0]         out_new_width,
  input logic [COORD_BITS-1:0]         out_new_height
);

  // a stalled word stays put
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_new_x) && $stable(out_new_y) &&
      $stable(out_new_width) && $stable(out_new_height))
    else $error("stalled output word changed");

  // input is held off exactly while the output word is blocked
  a_stall_on: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output blocked");

  a_stall_off: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && out_stall) |-> !in_stall)
    else $error("input stalled with output free");

  // reset flushes the pipeline
  a_reset_flush: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output word after reset");

endmodule

bind window_rect_remap wrr_checker u_wrr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_new_x      (out_new_x),
  .out_new_y      (out_new_y),
  .out_new_width  (out_new_width),
  .out_new_height (out_new_height)
);

// File: tb/sv/window_rect_remap_test.sv
// Self-checking testbench for window_rect_remap: directed table, then random phases with
// random input gaps and output stalls, results checked against the table or an in-bench predictor.
// Depends on wrr_pkg and window_rect_remap.
`timescale 1ns / 100ps

module window_rect_remap_test;
  import wrr_pkg::*;

  localparam int NUM_DIR      = 17;
  localparam int NUM_PHASES   = 14;
  localparam int PHASE_WORDS  = 124;
  localparam int PRESS_PHASE  = 3;
  localparam int HOLD_CYCLES  = 300;
  localparam int TAIL_CYCLES  = 40;
  localparam int IDLE_LIMIT   = 3000;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t w;
    coord_t h;
  } rect_t;

  typedef logic [0:NUM_REGS-1][COORD_BITS-1:0] reg_bank_t;

  typedef struct packed {
    logic [1:0] bank;
    rect_t      win;
    logic       typed;
    rect_t      want;
  } row_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       cfg_wr_en = 1'b0;
  reg_idx_t   cfg_index = '0;
  coord_t     cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  coord_t     in_win_x = '0;
  coord_t     in_win_y = '0;
  coord_t     in_win_width = '0;
  coord_t     in_win_height = '0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic signed [COORD_BITS-1:0] out_new_x;
  logic signed [COORD_BITS-1:0] out_new_y;
  coord_t     out_new_width;
  coord_t     out_new_height;

  coord_t     reg_shadow [NUM_REGS];
  rect_t      due_rects [$];
  int         mismatches = 0;
  int         idle_cycles = 0;
  bit         no_idle = 1'b0;
  bit         hold_wanted = 1'b0;

  // bank 0: reset values; 1: typical screens; 2: extreme screens; 3: small dest width
  reg_bank_t dir_banks [0:3] = '{
    '0,
    '{16'd0, 16'd0, 16'd1920, 16'd1080, 16'd100, 16'hffce, 16'd1280, 16'd720},
    '{16'h8000, 16'h8000, 16'hffff, 16'hffff, 16'h7fff, 16'h7fff, 16'hffff, 16'hffff},
    '{16'd10, 16'd20, 16'd100, 16'd100, 16'd0, 16'd0, 16'd50, 16'd200}
  };

  row_t dir_rows [0:NUM_DIR-1] = '{
    '{2'd0, '{16'h0000, 16'h0000, 16'h0000, 16'h0000}, 1'b1,
      '{16'h0000, 16'h0000, 16'h0001, 16'h0001}},
    '{2'd0, '{16'h8000, 16'h7fff, 16'hffff, 16'hffff}, 1'b1,
      '{16'h8000, 16'h0000, 16'h0000, 16'h7fff}},
    '{2'd0, '{16'd100, 16'hff9c, 16'd5, 16'd300}, 1'b1,
      '{16'h0000, 16'hff9c, 16'd106, 16'd301}},
    '{2'd1, '{16'd100, 16'd100, 16'd200, 16'd150}, 1'b0, '0},
    '{2'd1, '{16'hffce, 16'hffe2, 16'd300, 16'd200}, 1'b0, '0},
    '{2'd1, '{16'd1800, 16'd1000, 16'd400, 16'd200}, 1'b0, '0},
    '{2'd1, '{16'd5000, 16'hec78, 16'd10, 16'd10}, 1'b0, '0},
    '{2'd1, '{16'd500, 16'd500, 16'd0, 16'd0}, 1'b0, '0},
    '{2'd1, '{16'hfff6, 16'hfff6, 16'd3000, 16'd2000}, 1'b0, '0},
    '{2'd1, '{16'd1919, 16'd1079, 16'd1, 16'd1}, 1'b0, '0},
    '{2'd2, '{16'd32000, 16'd32000, 16'd1, 16'd1}, 1'b0, '0},
    '{2'd2, '{16'h0000, 16'h0000, 16'hffff, 16'hffff}, 1'b0, '0},
    '{2'd2, '{16'h8000, 16'h8000, 16'd1, 16'd1}, 1'b0, '0},
    '{2'd2, '{16'h7fff, 16'h8000, 16'hffff, 16'd1}, 1'b0, '0},
    '{2'd3, '{16'd50, 16'd60, 16'd80, 16'd90}, 1'b0, '0},
    '{2'd3, '{16'd10, 16'd20, 16'd100, 16'd100}, 1'b0, '0},
    '{2'd3, '{16'hfffb, 16'h0000, 16'd1, 16'd1}, 1'b0, '0}
  };

  window_rect_remap u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_win_x       (in_win_x),
    .in_win_y       (in_win_y),
    .in_win_width   (in_win_width),
    .in_win_height  (in_win_height),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_new_x      (out_new_x),
    .out_new_y      (out_new_y),
    .out_new_width  (out_new_width),
    .out_new_height (out_new_height)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // one axis: clip to the source, scale the offset across the free spans, restore
  function automatic void remap_span(input coord_t p_in, input coord_t s_in,
                                     input coord_t sp_in, input coord_t ss_in,
                                     input coord_t dp_in, input coord_t ds_in,
                                     output coord_t p_out, output coord_t s_out);
    longint pos, size, sp, ss, dp, ds;
    longint lo_over, hi_over, inner, shift_in, gap_src, gap_dst;
    longint unsigned num, den, mul, shift;
    pos = longint'($signed(p_in));
    size = longint'(s_in);
    sp = longint'($signed(sp_in));
    ss = longint'(ss_in);
    dp = longint'($signed(dp_in));
    ds = longint'(ds_in);
    lo_over = sp - pos;
    if (lo_over < 0) lo_over = 0;
    hi_over = (pos + size) - (sp + ss);
    if (hi_over < 0) hi_over = 0;
    inner = size - lo_over - hi_over;
    if (inner <= 0) inner = 1;
    shift_in = pos + lo_over - sp;
    gap_src = ss - inner;
    gap_dst = ds - inner;
    shift = 0;
    if (gap_src > 0 && gap_dst > 0 && shift_in > 0) begin
      num = shift_in;
      den = gap_src;
      mul = gap_dst;
      shift = (num / den) * mul + ((num % den) * mul) / den;
    end
    s_out = coord_t'(inner + lo_over + hi_over);
    p_out = coord_t'(longint'(dp) + longint'(shift) - lo_over);
  endfunction

  function automatic rect_t remap_rect(input rect_t win);
    rect_t r;
    remap_span(win.x, win.w, reg_shadow[REG_SRC_X], reg_shadow[REG_SRC_W],
               reg_shadow[REG_DST_X], reg_shadow[REG_DST_W], r.x, r.w);
    remap_span(win.y, win.h, reg_shadow[REG_SRC_Y], reg_shadow[REG_SRC_H],
               reg_shadow[REG_DST_Y], reg_shadow[REG_DST_H], r.y, r.h);
    return r;
  endfunction

  function automatic coord_t corner_val();
    case ($urandom_range(0, 3))
      0: return 16'h8000;
      1: return 16'h7fff;
      2: return 16'h0000;
      default: return 16'hffff;
    endcase
  endfunction

  function automatic int idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 60);
  endfunction

  // mostly windows near the source span, some anywhere, some at the corners
  function automatic void roll_axis(input coord_t sp, input coord_t ss,
                                    output coord_t p, output coord_t s);
    int unsigned span;
    span = ss;
    case ($urandom_range(0, 9))
      0, 1: begin
        p = coord_t'($urandom);
        s = coord_t'($urandom);
      end
      2: begin
        p = corner_val();
        s = corner_val();
      end
      default: begin
        p = sp + coord_t'($urandom_range(0, span + 64)) - 16'd32;
        s = coord_t'($urandom_range(0, span / 2 + 16));
      end
    endcase
  endfunction

  function automatic rect_t roll_rect();
    rect_t r;
    roll_axis(reg_shadow[REG_SRC_X], reg_shadow[REG_SRC_W], r.x, r.w);
    roll_axis(reg_shadow[REG_SRC_Y], reg_shadow[REG_SRC_H], r.y, r.h);
    return r;
  endfunction

  function automatic reg_bank_t roll_regs();
    reg_bank_t b;
    int unsigned r;
    bit is_pos;
    for (int i = 0; i < NUM_REGS; i++) begin
      case (reg_idx_t'(i))
        REG_SRC_X, REG_SRC_Y, REG_DST_X, REG_DST_Y: is_pos = 1'b1;
        default: is_pos = 1'b0;
      endcase
      r = $urandom_range(0, 7);
      if (r == 0) b[i] = is_pos ? 16'h8000 : 16'h0000;
      else if (r == 1) b[i] = is_pos ? 16'h7fff : 16'hffff;
      else if (r == 2) b[i] = coord_t'($urandom);
      else if (is_pos) b[i] = coord_t'($urandom_range(0, 4000)) - 16'd2000;
      else b[i] = coord_t'($urandom_range(0, 4000));
    end
    return b;
  endfunction

  task automatic log_error(input string msg);
    $display("%0t ERROR %s", $realtime, msg);
    mismatches++;
  endtask

  task automatic check_field(input string name, input coord_t got, input coord_t want);
    if (got !== want) log_error($sformatf("%s got %h want %h", name, got, want));
  endtask

  task automatic load_regs(input reg_bank_t bank);
    for (int i = 0; i < NUM_REGS; i++) begin
      cfg_wr_en <= 1'b1;
      cfg_index <= reg_idx_t'(i);
      cfg_wdata <= bank[i];
      @(posedge clk);
      reg_shadow[i] = bank[i];
    end
    cfg_wr_en <= 1'b0;
  endtask

  task automatic settle();
    while (due_rects.size() != 0) @(posedge clk);
  endtask

  task automatic send_rect(input rect_t win, input logic typed, input rect_t want);
    in_valid <= 1'b1;
    in_win_x <= win.x;
    in_win_y <= win.y;
    in_win_width <= win.w;
    in_win_height <= win.h;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    due_rects.push_back(typed ? want : remap_rect(win));
  endtask

  task automatic pause_sender();
    int rest;
    rest = no_idle ? 0 : idle_len();
    if (rest > 0) begin
      in_valid <= 1'b0;
      repeat (rest) @(posedge clk);
    end
  endtask

  // result-side stall pattern; a long hold-off when requested
  initial begin
    bit stall_on;
    int n;
    forever begin
      if (hold_wanted) begin
        hold_wanted = 1'b0;
        stall_on = 1'b1;
        n = HOLD_CYCLES;
      end else if (no_idle) begin
        stall_on = 1'b0;
        n = 1;
      end else begin
        stall_on = ($urandom_range(0, 3) == 0);
        n = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 50) : $urandom_range(1, 3);
      end
      out_stall <= stall_on;
      repeat (n) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    rect_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (due_rects.size() == 0) begin
        log_error($sformatf("unexpected word x=%h y=%h w=%h h=%h",
                            out_new_x, out_new_y, out_new_width, out_new_height));
      end else begin
        want = due_rects.pop_front();
        check_field("new_x", out_new_x, want.x);
        check_field("new_y", out_new_y, want.y);
        check_field("new_width", out_new_width, want.w);
        check_field("new_height", out_new_height, want.h);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no word moved for %0d cycles", IDLE_LIMIT);
        $display("window_rect_remap_test NOT OK");
        $finish;
      end
    end
  end

  initial begin
    logic [1:0] cur_bank;
    for (int i = 0; i < NUM_REGS; i++) reg_shadow[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    cur_bank = 2'd0;
    for (int k = 0; k < NUM_DIR; k++) begin
      if (dir_rows[k].bank != cur_bank) begin
        in_valid <= 1'b0;
        settle();
        load_regs(dir_banks[dir_rows[k].bank]);
        cur_bank = dir_rows[k].bank;
      end
      send_rect(dir_rows[k].win, dir_rows[k].typed, dir_rows[k].want);
      pause_sender();
    end

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      in_valid <= 1'b0;
      settle();
      no_idle = (ph % 5 == 1) || (ph == PRESS_PHASE);
      load_regs(roll_regs());
      if (ph == PRESS_PHASE) hold_wanted = 1'b1;
      for (int n = 0; n < PHASE_WORDS; n++) begin
        send_rect(roll_rect(), 1'b0, '0);
        pause_sender();
      end
    end

    in_valid <= 1'b0;
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("window_rect_remap_test OK");
    end else begin
      $display("window_rect_remap_test NOT OK");
    end
    $finish;
  end

endmodule
